// ----- rtl/ecdf_emd_pkg.sv -----
// ----------------------------------------------------------------------------
// ecdf_emd_pkg
// Shared sizes, payload types, codes and helpers for the ecdf distance core
// ----------------------------------------------------------------------------
package ecdf_emd_pkg;

    localparam int MAX_POINTS         = 1024;
    localparam int LOCATION_BITS      = 32;
    localparam int MASS_FRACTION_BITS = 16;
    localparam int LOC_FRAC_BITS      = 16;

    localparam int MASS_W  = MASS_FRACTION_BITS + 1;
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int START_W = ((LOCATION_BITS > LOC_FRAC_BITS + 1) ?
                              LOCATION_BITS : LOC_FRAC_BITS + 1) + 1;
    localparam int DIFF_W  = START_W + 1;
    localparam int PROD_W  = DIFF_W + MASS_W + 1;
    localparam int DIST_W  = 63;
    localparam int ACC_MIN = PROD_W + CNT_W + 1;
    localparam int ACC_W   = (ACC_MIN > DIST_W + 2) ? ACC_MIN : DIST_W + 2;
    localparam int ENTRY_W = LOCATION_BITS + MASS_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [MASS_W-1:0] FULL_MASS = {1'b1, {MASS_FRACTION_BITS{1'b0}}};
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0]  CNT_ONE   = {{(CNT_W-1){1'b0}}, 1'b1};
    localparam logic signed [DIFF_W-1:0] LOC_ONE =
        {{(DIFF_W-LOC_FRAC_BITS-1){1'b0}}, 1'b1, {LOC_FRAC_BITS{1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic LIST_FIRST  = 1'b0;
    localparam logic LIST_SECOND = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    typedef struct packed {
        logic                            func;
        logic signed [LOCATION_BITS-1:0] location;
        logic [MASS_W-1:0]               mass;
        logic                            last_point;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [1:0]        status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_START,
        ST_LOAD,
        ST_STEP,
        ST_DRAIN0,
        ST_DRAIN1,
        ST_RESULT
    } back_state_t;

    typedef enum logic [1:0] {
        MODE_MERGE,
        MODE_TAIL1,
        MODE_TAIL2
    } sweep_mode_t;

    function automatic logic signed [DIFF_W-1:0] loc_to_diff(
        input logic signed [LOCATION_BITS-1:0] loc
    );
        return {{(DIFF_W-LOCATION_BITS){loc[LOCATION_BITS-1]}}, loc};
    endfunction

    function automatic logic signed [DIFF_W-1:0] start_to_diff(
        input logic signed [START_W-1:0] start
    );
        return {start[START_W-1], start};
    endfunction

endpackage

// ----- rtl/ecdf_emd_ram.sv -----
// ----------------------------------------------------------------------------
// ecdf_emd_ram
// Generic single write port, single read port RAM with registered read data
// ----------------------------------------------------------------------------
module ecdf_emd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ecdf_emd_front.sv -----
// ----------------------------------------------------------------------------
// ecdf_emd_front
// Accepts points, clamps masses to one and buffers them in a short queue
// ----------------------------------------------------------------------------
module ecdf_emd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ecdf_emd_pkg::in_item_t s_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output ecdf_emd_pkg::in_item_t q_data
);

    ecdf_emd_pkg::in_item_t            queue_reg [ecdf_emd_pkg::QUEUE_DEPTH];
    logic [ecdf_emd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ecdf_emd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ecdf_emd_pkg::QPTR_W:0]     fill_reg, fill_next;
    ecdf_emd_pkg::in_item_t            item;
    logic                              push, pop;

    assign s_ready = (fill_reg != (ecdf_emd_pkg::QPTR_W+1)'(ecdf_emd_pkg::QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_data  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // clamp mass above one
    always_comb begin
        item = s_data;
        if (s_data.mass > ecdf_emd_pkg::FULL_MASS) begin
            item.mass = ecdf_emd_pkg::FULL_MASS;
        end
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- rtl/ecdf_emd_back.sv -----
// ----------------------------------------------------------------------------
// ecdf_emd_back
// Stores points per list, runs the merged sweep and holds the result register
// ----------------------------------------------------------------------------
module ecdf_emd_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  ecdf_emd_pkg::in_item_t  q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ecdf_emd_pkg::out_item_t m_data
);

    localparam int CNT_W   = ecdf_emd_pkg::CNT_W;
    localparam int ADDR_W  = ecdf_emd_pkg::ADDR_W;
    localparam int MASS_W  = ecdf_emd_pkg::MASS_W;
    localparam int START_W = ecdf_emd_pkg::START_W;
    localparam int DIFF_W  = ecdf_emd_pkg::DIFF_W;
    localparam int PROD_W  = ecdf_emd_pkg::PROD_W;
    localparam int ACC_W   = ecdf_emd_pkg::ACC_W;
    localparam int DIST_W  = ecdf_emd_pkg::DIST_W;
    localparam int ENTRY_W = ecdf_emd_pkg::ENTRY_W;
    localparam int LOC_W   = ecdf_emd_pkg::LOCATION_BITS;

    ecdf_emd_pkg::back_state_t  state_reg, state_next;
    ecdf_emd_pkg::sweep_mode_t  mode_reg, mode_next;
    logic [CNT_W-1:0]           cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;
    logic                       ovf_reg, ovf_next;
    logic [CNT_W-1:0]           i_reg, i_next, j_reg, j_next;
    logic [MASS_W-1:0]          v1_reg, v1_next, v2_reg, v2_next;
    logic signed [START_W-1:0]  start_reg, start_next;
    logic signed [DIFF_W-1:0]   op_w_reg, op_w_next;
    logic [MASS_W-1:0]          op_g_reg, op_g_next;
    logic                       op_vld_reg, prod_vld_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    ecdf_emd_pkg::out_item_t    out_reg, out_next;
    logic                       out_vld_reg, out_vld_next;

    logic                       pop, out_free, early_done, exhausted, take1;
    logic                       we1, we2;
    logic [ENTRY_W-1:0]         wdata, rd1, rd2;
    logic signed [LOC_W-1:0]    rd1_loc, rd2_loc;
    logic [MASS_W-1:0]          rd1_mass, rd2_mass, gap;
    logic signed [DIFF_W-1:0]   l1, l2, chosen, width;
    logic [CNT_W-1:0]           i_inc, j_inc;
    logic [1:0]                 early_status;
    ecdf_emd_pkg::out_item_t    sweep_result;

    assign q_ready  = (state_reg == ecdf_emd_pkg::ST_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !out_vld_reg || m_ready;
    assign m_valid  = out_vld_reg;
    assign m_data   = out_reg;

    // point storage
    assign wdata = {q_data.location, q_data.mass};
    assign we1   = pop && (q_data.func == ecdf_emd_pkg::LIST_FIRST) &&
                   (cnt1_reg != ecdf_emd_pkg::CNT_FULL);
    assign we2   = pop && (q_data.func == ecdf_emd_pkg::LIST_SECOND) &&
                   (cnt2_reg != ecdf_emd_pkg::CNT_FULL);

    ecdf_emd_ram #(.WIDTH(ENTRY_W), .DEPTH(ecdf_emd_pkg::MAX_POINTS)) u_ram_first (
        .aclk  (aclk),
        .we    (we1),
        .waddr (cnt1_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (i_reg[ADDR_W-1:0]),
        .rdata (rd1)
    );

    ecdf_emd_ram #(.WIDTH(ENTRY_W), .DEPTH(ecdf_emd_pkg::MAX_POINTS)) u_ram_second (
        .aclk  (aclk),
        .we    (we2),
        .waddr (cnt2_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (j_reg[ADDR_W-1:0]),
        .rdata (rd2)
    );

    assign rd1_loc  = rd1[ENTRY_W-1:MASS_W];
    assign rd1_mass = rd1[MASS_W-1:0];
    assign rd2_loc  = rd2[ENTRY_W-1:MASS_W];
    assign rd2_mass = rd2[MASS_W-1:0];
    assign l1       = ecdf_emd_pkg::loc_to_diff(rd1_loc);
    assign l2       = ecdf_emd_pkg::loc_to_diff(rd2_loc);

    // sweep step
    assign take1  = (mode_reg == ecdf_emd_pkg::MODE_MERGE) ? (l1 < l2) :
                    (mode_reg == ecdf_emd_pkg::MODE_TAIL1);
    assign chosen = take1 ? l1 : l2;
    assign width  = chosen - ecdf_emd_pkg::start_to_diff(start_reg);
    assign i_inc  = i_reg + ecdf_emd_pkg::CNT_ONE;
    assign j_inc  = j_reg + ecdf_emd_pkg::CNT_ONE;
    assign exhausted = take1 ? (i_inc >= cnt1_reg) : (j_inc >= cnt2_reg);

    always_comb begin
        if (mode_reg == ecdf_emd_pkg::MODE_MERGE) begin
            gap = (v1_reg > v2_reg) ? v1_reg - v2_reg : v2_reg - v1_reg;
        end else if (take1) begin
            gap = ecdf_emd_pkg::FULL_MASS - v1_reg;
        end else begin
            gap = ecdf_emd_pkg::FULL_MASS - v2_reg;
        end
    end

    assign early_done = (cnt1_reg == '0) || (cnt2_reg == '0) || ovf_reg;
    assign early_status = ((cnt1_reg == '0) || (cnt2_reg == '0)) ?
                          ecdf_emd_pkg::STATUS_EMPTY : ecdf_emd_pkg::STATUS_OVERFLOW;

    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            sweep_result.distance = '0;
            sweep_result.status   = ecdf_emd_pkg::STATUS_SATURATED;
        end else if (|acc_reg[ACC_W-2:DIST_W]) begin
            sweep_result.distance = ecdf_emd_pkg::DIST_MAX;
            sweep_result.status   = ecdf_emd_pkg::STATUS_SATURATED;
        end else begin
            sweep_result.distance = acc_reg[DIST_W-1:0];
            sweep_result.status   = ecdf_emd_pkg::STATUS_OK;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ecdf_emd_pkg::ST_IDLE: begin
                if (pop && q_data.last_point) begin
                    state_next = ecdf_emd_pkg::ST_DECIDE;
                end
            end
            ecdf_emd_pkg::ST_DECIDE: begin
                if (!early_done) begin
                    state_next = ecdf_emd_pkg::ST_START;
                end else if (out_free) begin
                    state_next = ecdf_emd_pkg::ST_IDLE;
                end
            end
            ecdf_emd_pkg::ST_START:  state_next = ecdf_emd_pkg::ST_STEP;
            ecdf_emd_pkg::ST_LOAD:   state_next = ecdf_emd_pkg::ST_STEP;
            ecdf_emd_pkg::ST_STEP: begin
                if (exhausted && (mode_reg != ecdf_emd_pkg::MODE_MERGE)) begin
                    state_next = ecdf_emd_pkg::ST_DRAIN0;
                end else begin
                    state_next = ecdf_emd_pkg::ST_LOAD;
                end
            end
            ecdf_emd_pkg::ST_DRAIN0: state_next = ecdf_emd_pkg::ST_DRAIN1;
            ecdf_emd_pkg::ST_DRAIN1: state_next = ecdf_emd_pkg::ST_RESULT;
            ecdf_emd_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = ecdf_emd_pkg::ST_IDLE;
                end
            end
            default: state_next = ecdf_emd_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        mode_next    = mode_reg;
        cnt1_next    = cnt1_reg;
        cnt2_next    = cnt2_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        v1_next      = v1_reg;
        v2_next      = v2_reg;
        start_next   = start_reg;
        op_w_next    = width;
        op_g_next    = gap;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_ready;
        acc_next     = acc_reg;
        if (prod_vld_reg) begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        unique case (state_reg)
            ecdf_emd_pkg::ST_IDLE: begin
                if (pop) begin
                    if (q_data.func == ecdf_emd_pkg::LIST_FIRST) begin
                        if (we1) begin
                            cnt1_next = cnt1_reg + ecdf_emd_pkg::CNT_ONE;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        if (we2) begin
                            cnt2_next = cnt2_reg + ecdf_emd_pkg::CNT_ONE;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            ecdf_emd_pkg::ST_DECIDE: begin
                acc_next  = '0;
                v1_next   = '0;
                v2_next   = '0;
                mode_next = ecdf_emd_pkg::MODE_MERGE;
                if (early_done && out_free) begin
                    out_next.distance = '0;
                    out_next.status   = early_status;
                    out_vld_next      = 1'b1;
                    cnt1_next         = '0;
                    cnt2_next         = '0;
                    ovf_next          = 1'b0;
                end
            end
            ecdf_emd_pkg::ST_START: begin
                start_next = START_W'(((l1 < l2) ? l1 : l2) - ecdf_emd_pkg::LOC_ONE);
            end
            ecdf_emd_pkg::ST_STEP: begin
                start_next = START_W'(chosen);
                if (take1) begin
                    v1_next = rd1_mass;
                    i_next  = i_inc;
                end else begin
                    v2_next = rd2_mass;
                    j_next  = j_inc;
                end
                if (exhausted && (mode_reg == ecdf_emd_pkg::MODE_MERGE)) begin
                    mode_next = take1 ? ecdf_emd_pkg::MODE_TAIL2 : ecdf_emd_pkg::MODE_TAIL1;
                end
            end
            ecdf_emd_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_next     = sweep_result;
                    out_vld_next = 1'b1;
                    cnt1_next    = '0;
                    cnt2_next    = '0;
                    ovf_next     = 1'b0;
                    i_next       = '0;
                    j_next       = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ecdf_emd_pkg::ST_IDLE;
            mode_reg     <= ecdf_emd_pkg::MODE_MERGE;
            cnt1_reg     <= '0;
            cnt2_reg     <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            op_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cnt1_reg     <= cnt1_next;
            cnt2_reg     <= cnt2_next;
            ovf_reg      <= ovf_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            op_vld_reg   <= (state_reg == ecdf_emd_pkg::ST_STEP);
            prod_vld_reg <= op_vld_reg;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        v1_reg    <= v1_next;
        v2_reg    <= v2_next;
        start_reg <= start_next;
        op_w_reg  <= op_w_next;
        op_g_reg  <= op_g_next;
        prod_reg  <= PROD_W'(op_w_reg) * PROD_W'($signed({1'b0, op_g_reg}));
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

endmodule

// ----- rtl/ecdf_earth_movers_distance_core.sv -----
// ----------------------------------------------------------------------------
// ecdf_earth_movers_distance_core
// Earth mover's distance between two stepwise cumulative distributions
// ----------------------------------------------------------------------------
// Loading: one point per cycle while the four-entry queue has room;
// the back end stores one per cycle while idle. Sweep: for each stored
// point, a registered memory read, then one step. When a list is empty
// or has overflowed, the result is given without a sweep.
// Reset (aresetn low, synchronous) empties the queue, both lists and the result register.
module ecdf_earth_movers_distance_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ecdf_emd_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ecdf_emd_pkg::out_item_t m_data
);

    ecdf_emd_pkg::in_item_t q_data;
    logic                   q_valid, q_ready;

    ecdf_emd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    ecdf_emd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/ecdf_emd_checker.sv -----
// ----------------------------------------------------------------------------
// ecdf_emd_checker
// Port-level checks on the result channel of the ecdf distance core
// ----------------------------------------------------------------------------
module ecdf_emd_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input ecdf_emd_pkg::out_item_t m_data
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // empty or overflowed lists give zero distance
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ecdf_emd_pkg::STATUS_EMPTY ||
                    m_data.status == ecdf_emd_pkg::STATUS_OVERFLOW)
        |-> m_data.distance == '0)
        else $error("flagged transaction with non-zero distance");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ecdf_emd_pkg::STATUS_SATURATED
        |-> m_data.distance == '0 || m_data.distance == ecdf_emd_pkg::DIST_MAX)
        else $error("saturated transaction with unclamped distance");

    // queue empty and accepting once reset has been applied
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind ecdf_earth_movers_distance_core ecdf_emd_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/ecdf_earth_movers_distance_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdf_earth_movers_distance_core_tb
// Loads pairs of stepwise cumulative distributions point by point through the
// input channel and checks every distance and status against a local model of
// the merged sweep. The checks cover short directed sets (ties, extreme
// locations, clamped mass, empty lists, a negative total), random well-formed
// and broken sets, and one set that overflows a list, all under shifting
// idle patterns on both channels.
// ----------------------------------------------------------------------------
module ecdf_earth_movers_distance_core_tb;

    localparam int    ITEM_TARGET  = 1750;
    localparam int    GEN_DEPTH    = ecdf_emd_pkg::MAX_POINTS + 2;
    localparam int    LIMIT_CYCLES = 400000;
    localparam int    TAIL_CYCLES  = 60;
    localparam longint LOC_MIN     = -64'sd2147483648;
    localparam longint LOC_SPAN    = 64'sd4294967296;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    ecdf_emd_pkg::in_item_t  s_data  = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    ecdf_emd_pkg::out_item_t m_data;

    ecdf_earth_movers_distance_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ecdf_emd_pkg::in_item_t  point_queue[$];
    ecdf_emd_pkg::out_item_t pending_distances[$];
    int          stim_total = 0;
    int          sent_count = 0;
    int          result_count = 0;
    int          err_count = 0;
    int          cycle_count = 0;
    int          status_seen[4];
    int          sender_idle_pct;
    int          receiver_idle_pct;

    // model state of the two lists
    longint      stored_loc[2][ecdf_emd_pkg::MAX_POINTS];
    int unsigned stored_mass[2][ecdf_emd_pkg::MAX_POINTS];
    int unsigned stored_count[2];
    bit          dropped_point;

    // scratch lists for building stimulus sets
    longint      gen_loc[2][GEN_DEPTH];
    int unsigned gen_mass[2][GEN_DEPTH];

    assign sender_idle_pct   = (sent_count < stim_total / 3) ? 37 :
                               (sent_count < 2 * stim_total / 3) ? 70 : 0;
    assign receiver_idle_pct = (sent_count < stim_total / 3) ? 70 :
                               (sent_count < 2 * stim_total / 3) ? 37 : 0;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic logic signed [127:0] strip_area(input longint w, input int unsigned g);
        logic signed [127:0] ws;
        logic signed [127:0] gs;
        ws = w;
        gs = {96'b0, g};
        return ws * gs;
    endfunction

    function automatic ecdf_emd_pkg::out_item_t sweep_distance();
        logic signed [127:0]     area;
        longint                  from_loc;
        int unsigned             m1;
        int unsigned             m2;
        int unsigned             i;
        int unsigned             j;
        int unsigned             full;
        int unsigned             la;
        int unsigned             lb;
        ecdf_emd_pkg::out_item_t res;
        area = '0;
        m1   = 0;
        m2   = 0;
        i    = 0;
        j    = 0;
        la   = ecdf_emd_pkg::LIST_FIRST;
        lb   = ecdf_emd_pkg::LIST_SECOND;
        full = ecdf_emd_pkg::FULL_MASS;
        from_loc = (stored_loc[la][0] < stored_loc[lb][0]) ?
                   stored_loc[la][0] : stored_loc[lb][0];
        from_loc = from_loc - (longint'(1) << ecdf_emd_pkg::LOC_FRAC_BITS);
        while (i < stored_count[la] && j < stored_count[lb]) begin
            if (stored_loc[la][i] < stored_loc[lb][j]) begin
                area = area + strip_area(stored_loc[la][i] - from_loc,
                                         (m1 > m2) ? m1 - m2 : m2 - m1);
                m1 = stored_mass[la][i];
                from_loc = stored_loc[la][i];
                i++;
            end else begin
                area = area + strip_area(stored_loc[lb][j] - from_loc,
                                         (m1 > m2) ? m1 - m2 : m2 - m1);
                m2 = stored_mass[lb][j];
                from_loc = stored_loc[lb][j];
                j++;
            end
        end
        // tail of whichever list is left, weighted by that list's own missing mass
        while (j < stored_count[lb]) begin
            area = area + strip_area(stored_loc[lb][j] - from_loc, full - m2);
            m2 = stored_mass[lb][j];
            from_loc = stored_loc[lb][j];
            j++;
        end
        while (i < stored_count[la]) begin
            area = area + strip_area(stored_loc[la][i] - from_loc, full - m1);
            m1 = stored_mass[la][i];
            from_loc = stored_loc[la][i];
            i++;
        end
        if (area < 0) begin
            res.distance = '0;
            res.status   = ecdf_emd_pkg::STATUS_SATURATED;
        end else if (area > 128'sh7FFF_FFFF_FFFF_FFFF) begin
            res.distance = ecdf_emd_pkg::DIST_MAX;
            res.status   = ecdf_emd_pkg::STATUS_SATURATED;
        end else begin
            res.distance = area[ecdf_emd_pkg::DIST_W-1:0];
            res.status   = ecdf_emd_pkg::STATUS_OK;
        end
        return res;
    endfunction

    task automatic absorb_point(input ecdf_emd_pkg::in_item_t p);
        int unsigned             idx;
        int unsigned             m;
        ecdf_emd_pkg::out_item_t res;
        idx = p.func;
        m   = p.mass;
        if (m > ecdf_emd_pkg::FULL_MASS)
            m = ecdf_emd_pkg::FULL_MASS;
        if (stored_count[idx] < ecdf_emd_pkg::MAX_POINTS) begin
            stored_loc[idx][stored_count[idx]]  = longint'($signed(p.location));
            stored_mass[idx][stored_count[idx]] = m;
            stored_count[idx]++;
        end else begin
            dropped_point = 1'b1;
        end
        if (p.last_point) begin
            if (stored_count[ecdf_emd_pkg::LIST_FIRST] == 0 ||
                stored_count[ecdf_emd_pkg::LIST_SECOND] == 0) begin
                res.distance = '0;
                res.status   = ecdf_emd_pkg::STATUS_EMPTY;
            end else if (dropped_point) begin
                res.distance = '0;
                res.status   = ecdf_emd_pkg::STATUS_OVERFLOW;
            end else begin
                res = sweep_distance();
            end
            pending_distances.push_back(res);
            stored_count[ecdf_emd_pkg::LIST_FIRST]  = 0;
            stored_count[ecdf_emd_pkg::LIST_SECOND] = 0;
            dropped_point = 1'b0;
        end
    endtask

    task automatic push_point(input logic func, input longint loc, input int unsigned mass,
                              input logic last);
        ecdf_emd_pkg::in_item_t p;
        p.func       = func;
        p.location   = ecdf_emd_pkg::LOCATION_BITS'(loc);
        p.mass       = ecdf_emd_pkg::MASS_W'(mass);
        p.last_point = last;
        point_queue.push_back(p);
    endtask

    task automatic build_list(input int lst, input int n, input bit ordered, input longint base);
        longint      step_max;
        longint      cap;
        longint      room;
        longint      cur;
        int unsigned cur_m;
        int unsigned inc_max;
        int unsigned full;
        int          k;
        full = ecdf_emd_pkg::FULL_MASS;
        cap = 64'sd4294967295 / (n + 1);
        case ($urandom_range(3))
            0: step_max = 4;
            1: step_max = 65536;
            2: step_max = 1 << 20;
            default: step_max = cap;
        endcase
        if (step_max > cap)
            step_max = cap;
        room = LOC_SPAN - step_max * n;
        if (step_max == 4)
            cur = base;
        else
            cur = LOC_MIN + longint'({$urandom, $urandom} >> 1) % room;
        cur_m   = 0;
        inc_max = (2 * full) / (n + 1) + 1;
        for (k = 0; k < n; k++) begin
            if (ordered) begin
                cur = cur + $urandom_range(int'(step_max));
                cur_m = cur_m + $urandom_range(inc_max);
                if (cur_m > full)
                    cur_m = full;
                if (k == n - 1 && $urandom_range(7) == 0)
                    cur_m = full;
                gen_loc[lst][k]  = cur;
                gen_mass[lst][k] = cur_m;
                if ($urandom_range(19) == 0)
                    gen_mass[lst][k] = $urandom_range(131071, full + 1);
            end else begin
                gen_loc[lst][k]  = longint'($signed($urandom));
                gen_mass[lst][k] = ($urandom_range(3) == 0) ? $urandom_range(131071) :
                                                              $urandom_range(full);
            end
        end
    endtask

    task automatic add_ecdf_set(input int n_a, input int n_b, input bit ordered);
        int     n[2];
        int     pos[2];
        int     total;
        int     k;
        int     pick;
        longint base;
        n[0]   = n_a;
        n[1]   = n_b;
        pos[0] = 0;
        pos[1] = 0;
        base   = LOC_MIN + longint'($urandom) % (LOC_SPAN - 8 * GEN_DEPTH);
        build_list(ecdf_emd_pkg::LIST_FIRST, n_a, ordered, base);
        build_list(ecdf_emd_pkg::LIST_SECOND, n_b, ordered, base);
        total = n_a + n_b;
        for (k = 0; k < total; k++) begin
            if (pos[0] == n[0])
                pick = ecdf_emd_pkg::LIST_SECOND;
            else if (pos[1] == n[1])
                pick = ecdf_emd_pkg::LIST_FIRST;
            else
                pick = $urandom_range(1);
            push_point(1'(pick), gen_loc[pick][pos[pick]], gen_mass[pick][pos[pick]],
                       k == total - 1);
            pos[pick]++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_point(s_data);
                sent_count <= sent_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (point_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_data  <= point_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        ecdf_emd_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                status_seen[m_data.status]++;
                if (pending_distances.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result distance %0h status %0d",
                                            m_data.distance, m_data.status));
                end else begin
                    want = pending_distances.pop_front();
                    if (m_data.distance !== want.distance)
                        flag_mismatch($sformatf("distance %0h, expected %0h",
                                                m_data.distance, want.distance));
                    if (m_data.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                m_data.status, want.status));
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_distances.size());
            $display("ecdf_earth_movers_distance_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int r;
        int na;
        int nb;
        bit overflow_done;
        overflow_done = 1'b0;
        for (r = 0; r < 4; r++)
            status_seen[r] = 0;
        stored_count[ecdf_emd_pkg::LIST_FIRST]  = 0;
        stored_count[ecdf_emd_pkg::LIST_SECOND] = 0;
        dropped_point = 1'b0;

        // lone point of either list: the other list is empty
        push_point(ecdf_emd_pkg::LIST_FIRST, 0, ecdf_emd_pkg::FULL_MASS, 1'b1);
        push_point(ecdf_emd_pkg::LIST_SECOND, -1, 0, 1'b1);
        // minimal pair
        push_point(ecdf_emd_pkg::LIST_FIRST, 0, ecdf_emd_pkg::FULL_MASS, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 65536, ecdf_emd_pkg::FULL_MASS, 1'b1);
        // equal locations across the lists
        push_point(ecdf_emd_pkg::LIST_FIRST, 100, 32768, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 100, 32768, 1'b0);
        push_point(ecdf_emd_pkg::LIST_FIRST, 200, ecdf_emd_pkg::FULL_MASS, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 200, ecdf_emd_pkg::FULL_MASS, 1'b1);
        // extreme locations, zero mass and mass above one
        push_point(ecdf_emd_pkg::LIST_FIRST, LOC_MIN, 0, 1'b0);
        push_point(ecdf_emd_pkg::LIST_FIRST, 2147483647, ecdf_emd_pkg::FULL_MASS, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, LOC_MIN, 131071, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 2147483647, ecdf_emd_pkg::FULL_MASS, 1'b1);
        // gap of either sign
        push_point(ecdf_emd_pkg::LIST_FIRST, 0, 10000, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 65536, 60000, 1'b0);
        push_point(ecdf_emd_pkg::LIST_FIRST, 131072, ecdf_emd_pkg::FULL_MASS, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 196608, ecdf_emd_pkg::FULL_MASS, 1'b1);
        // widest single segment
        push_point(ecdf_emd_pkg::LIST_FIRST, LOC_MIN, ecdf_emd_pkg::FULL_MASS, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 2147483647, ecdf_emd_pkg::FULL_MASS, 1'b1);
        // descending locations drive the total negative
        push_point(ecdf_emd_pkg::LIST_FIRST, 0, 0, 1'b0);
        push_point(ecdf_emd_pkg::LIST_FIRST, LOC_MIN, 0, 1'b0);
        push_point(ecdf_emd_pkg::LIST_SECOND, 0, ecdf_emd_pkg::FULL_MASS, 1'b1);

        while (point_queue.size() < ITEM_TARGET) begin
            if (!overflow_done && point_queue.size() > ITEM_TARGET / 3) begin
                overflow_done = 1'b1;
                if ($urandom_range(1))
                    add_ecdf_set(ecdf_emd_pkg::MAX_POINTS + 1, 1, 1'b1);
                else
                    add_ecdf_set(1, ecdf_emd_pkg::MAX_POINTS + 1, 1'b1);
            end else begin
                r = $urandom_range(99);
                if (r < 8) begin
                    na = $urandom_range(4, 1);
                    nb = 0;
                    if ($urandom_range(1))
                        add_ecdf_set(na, nb, 1'b1);
                    else
                        add_ecdf_set(nb, na, 1'b1);
                end else if (r < 85) begin
                    add_ecdf_set($urandom_range(8, 1), $urandom_range(8, 1),
                                 $urandom_range(5) != 0);
                end else begin
                    add_ecdf_set($urandom_range(40, 9), $urandom_range(40, 1),
                                 $urandom_range(5) != 0);
                end
            end
        end
        stim_total = point_queue.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (point_queue.size() != 0 || s_valid)
            @(posedge aclk);
        while (pending_distances.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_distances.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_distances.size()));
        $display("covered %0d points and %0d distance results in %0d cycles",
                 sent_count, result_count, cycle_count);
        $display("statuses seen: ok %0d, empty %0d, overflow %0d, saturated %0d",
                 status_seen[ecdf_emd_pkg::STATUS_OK], status_seen[ecdf_emd_pkg::STATUS_EMPTY],
                 status_seen[ecdf_emd_pkg::STATUS_OVERFLOW],
                 status_seen[ecdf_emd_pkg::STATUS_SATURATED]);
        if (err_count == 0) begin
            $display("ecdf_earth_movers_distance_core_tb: done, clean");
        end else begin
            $display("ecdf_earth_movers_distance_core_tb: done, errors");
        end
        $finish;
    end

endmodule
